>>> src/rycc_pkg.sv
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// No dependencies; every other file of the block imports this package.
package rycc_pkg;

    // Geometry of the line store
    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_FW_W   = 12;
    localparam int CFG_FH_W   = 13;
    localparam int ROW_W      = CFG_FH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_FW_W-1:0] FRAME_WIDTH_RST  = CFG_FW_W'(640);
    localparam logic [CFG_FH_W-1:0] FRAME_HEIGHT_RST = CFG_FH_W'(480);

    // Pixel and pair-sum widths
    localparam int PIX_W = 8;
    localparam int SUM_W = PIX_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Luma coefficients, Q13
    localparam int Y_R_COEF  = 2104;
    localparam int Y_G_COEF  = 4130;
    localparam int Y_B_COEF  = 802;
    localparam int Y_BIAS    = 4096 + 131072;
    localparam int Y_MAX     = 235;
    localparam int Y_MIN     = 16;
    localparam int Y_SUM_W   = 21;

    // Chroma coefficients, Q13 (magnitudes; signs applied in the adder)
    localparam int CB_R_COEF = 1214;
    localparam int CB_G_COEF = 2384;
    localparam int CB_B_COEF = 3598;
    localparam int CR_R_COEF = 3598;
    localparam int CR_G_COEF = 3013;
    localparam int CR_B_COEF = 585;
    localparam int C_BIAS    = 4096 + 1048576;
    localparam int C_MIN     = 16;
    localparam int C_MAX     = 240;
    localparam int C_PROD_W  = 20;
    localparam int C_SUM_W   = 23;
    localparam int FRAC_W    = 13;

    // What the back end does with the line store for one pixel
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } t_pair_op;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
    } t_sum;

    // One classified pixel, front to back
    typedef struct packed {
        t_rgb              pix;
        t_sum              sums;
        t_pair_op          op;
        logic [ADDR_W-1:0] addr;
        logic              eol;
        logic              eof;
    } t_job;

    // Flags that ride along the back pipeline
    typedef struct packed {
        logic chroma;
        logic eol;
        logic eof;
    } t_tag;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

endpackage

>>> src/rycc_if.sv
// Channel interfaces of the converter: pixel input, result output, config write.
// Depends on rycc_pkg for field widths.
interface rycc_pix_if;
    import rycc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rycc_res_if;
    import rycc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb_value;
    logic [PIX_W-1:0] cr_value;
    logic             end_of_line;
    logic             end_of_frame;
    modport source (output valid, luma, chroma_valid, cb_value, cr_value,
                    end_of_line, end_of_frame, input ready);
    modport sink   (input valid, luma, chroma_valid, cb_value, cr_value,
                    end_of_line, end_of_frame, output ready);
endinterface

interface rycc_cfg_if;
    import rycc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/rycc_front.sv
// Front end: config registers, pixel accept, row/column tracking, pair sums.
// Depends on rycc_pkg and rycc_if; pushes one classified job per beat.
module rycc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rycc_cfg_if.sink        i_cfg,
    rycc_pix_if.sink        i_pix,
    input  rycc_pkg::t_qstat i_qstat,
    output logic            o_push,
    output rycc_pkg::t_job  o_job
);
    import rycc_pkg::*;

    logic [CFG_FW_W-1:0] r_frame_width;
    logic [CFG_FH_W-1:0] r_frame_height;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    t_rgb                r_left, n_left;
    logic [CFG_FW_W-1:0] width_eff;
    logic [CFG_FH_W-1:0] height_eff;
    logic                last_col;
    logic                last_row;
    logic                accept;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !i_qstat.full;
    assign accept      = i_pix.valid && i_pix.ready;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[CFG_FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[CFG_FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, width saturates at the store size
    always_comb begin
        priority if (r_frame_width == '0) begin
            width_eff = CFG_FW_W'(1);
        end else if (r_frame_width > CFG_FW_W'(MAX_WIDTH)) begin
            width_eff = CFG_FW_W'(MAX_WIDTH);
        end else begin
            width_eff = r_frame_width;
        end
        height_eff = (r_frame_height == '0) ? CFG_FH_W'(1) : r_frame_height;
    end

    assign last_col = (CFG_FW_W'(r_col) + CFG_FW_W'(1)) >= width_eff;
    assign last_row = ((ROW_W+1)'(r_row) + (ROW_W+1)'(1)) >= (ROW_W+1)'(height_eff);

    // Classify the beat and form the horizontal pair sums
    always_comb begin
        o_job.pix.red        = i_pix.red;
        o_job.pix.green      = i_pix.green;
        o_job.pix.blue       = i_pix.blue;
        o_job.sums.sum_red   = SUM_W'(r_left.red)   + SUM_W'(i_pix.red);
        o_job.sums.sum_green = SUM_W'(r_left.green) + SUM_W'(i_pix.green);
        o_job.sums.sum_blue  = SUM_W'(r_left.blue)  + SUM_W'(i_pix.blue);
        if (r_col[0]) begin
            o_job.op = r_row[0] ? OP_READ : OP_WRITE;
        end else begin
            o_job.op = OP_NONE;
        end
        o_job.addr = r_col[COL_W-1:1];
        o_job.eol  = last_col;
        o_job.eof  = last_col && last_row;
    end

    assign o_push = accept;

    // Position counters and left-pixel hold
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        if (accept) begin
            n_left = o_job.pix;
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= n_left;
        end
    end

endmodule

>>> src/rycc_queue.sv
// Short job queue between the front and back ends.
// Depends on rycc_pkg for the job type and depth.
module rycc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rycc_pkg::t_job   i_job,
    input  logic             i_pop,
    output rycc_pkg::t_qstat o_qstat,
    output rycc_pkg::t_job   o_head
);
    import rycc_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    assign o_qstat.full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_qstat.valid = (r_cnt != '0);
    assign o_head        = r_slot[r_rptr];

    // Pointer and fill count update
    always_comb begin
        n_wptr = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr = i_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QPTR_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_qstat.valid)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> src/rycc_back.sv
// Back end: line store, luma and chroma datapath, output register.
// Depends on rycc_pkg and rycc_if; pops one job per beat when not stalled.
module rycc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rycc_pkg::t_qstat i_qstat,
    input  rycc_pkg::t_job   i_head,
    output logic             o_pop,
    rycc_res_if.source       o_res
);
    import rycc_pkg::*;

    function automatic logic [PIX_W-1:0] chroma_clamp(input logic [C_SUM_W-1:0] v);
        logic [C_SUM_W-FRAC_W-1:0] q;
        begin
            q = v[C_SUM_W-1:FRAC_W];
            if (v[C_SUM_W-1] || q < (C_SUM_W-FRAC_W)'(C_MIN)) begin
                chroma_clamp = PIX_W'(C_MIN);
            end else if (q > (C_SUM_W-FRAC_W)'(C_MAX)) begin
                chroma_clamp = PIX_W'(C_MAX);
            end else begin
                chroma_clamp = q[PIX_W-1:0];
            end
        end
    endfunction

    // Line store of even-row pair sums
    t_sum r_store [STORE_DEPTH];

    // Stage valids and enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // Stage 1: store read, luma products
    t_sum                 r_s1_sums;
    t_sum                 r_s1_rd;
    logic [Y_SUM_W-1:0]   r_s1_py_r, r_s1_py_g, r_s1_py_b;
    t_tag                 r_s1_tag;
    // Stage 2: block averages, luma
    logic [PIX_W-1:0]     r_s2_ar, r_s2_ag, r_s2_ab;
    logic [PIX_W-1:0]     r_s2_luma;
    t_tag                 r_s2_tag;
    // Stage 3: chroma products
    logic [C_PROD_W-1:0]  r_s3_cb_r, r_s3_cb_g, r_s3_cb_b;
    logic [C_PROD_W-1:0]  r_s3_cr_r, r_s3_cr_g, r_s3_cr_b;
    logic [PIX_W-1:0]     r_s3_luma;
    t_tag                 r_s3_tag;
    // Output register
    logic [PIX_W-1:0]     r_o_luma, r_o_cb, r_o_cr;
    t_tag                 r_o_tag;

    t_tag                 head_tag;
    logic [Y_SUM_W-1:0]   y_sum;
    logic [PIX_W-1:0]     y_q, y_clamped;
    logic [SUM_W+1:0]     blk_r, blk_g, blk_b;
    logic [C_SUM_W-1:0]   cb_sum, cr_sum;
    logic [PIX_W-1:0]     cb_out, cr_out;

    // Bubble-collapsing stall chain from the output back to the queue
    assign en4   = !r_v4 || o_res.ready;
    assign en3   = !r_v3 || en4;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_qstat.valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_qstat.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: odd column of an even row writes, odd column of an odd row reads
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_WRITE) begin
            r_store[i_head.addr] <= i_head.sums;
        end
        if (en1) begin
            r_s1_rd <= r_store[i_head.addr];
        end
    end

    assign head_tag.chroma = (i_head.op == OP_READ);
    assign head_tag.eol    = i_head.eol;
    assign head_tag.eof    = i_head.eof;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sums <= i_head.sums;
            r_s1_py_r <= Y_SUM_W'(i_head.pix.red)   * Y_SUM_W'(Y_R_COEF);
            r_s1_py_g <= Y_SUM_W'(i_head.pix.green) * Y_SUM_W'(Y_G_COEF);
            r_s1_py_b <= Y_SUM_W'(i_head.pix.blue)  * Y_SUM_W'(Y_B_COEF);
            r_s1_tag  <= head_tag;
        end
    end

    // Stage 2: luma sum and clamp, rounded 2x2 averages
    assign y_sum = r_s1_py_r + r_s1_py_g + r_s1_py_b + Y_SUM_W'(Y_BIAS);
    assign y_q   = y_sum[Y_SUM_W-1:FRAC_W];
    assign y_clamped = (y_q > PIX_W'(Y_MAX)) ? PIX_W'(Y_MAX) : y_q;

    assign blk_r = (SUM_W+2)'(r_s1_sums.sum_red)   + (SUM_W+2)'(r_s1_rd.sum_red)
                 + (SUM_W+2)'(2);
    assign blk_g = (SUM_W+2)'(r_s1_sums.sum_green) + (SUM_W+2)'(r_s1_rd.sum_green)
                 + (SUM_W+2)'(2);
    assign blk_b = (SUM_W+2)'(r_s1_sums.sum_blue)  + (SUM_W+2)'(r_s1_rd.sum_blue)
                 + (SUM_W+2)'(2);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_ar   <= blk_r[SUM_W:2];
            r_s2_ag   <= blk_g[SUM_W:2];
            r_s2_ab   <= blk_b[SUM_W:2];
            r_s2_luma <= y_clamped;
            r_s2_tag  <= r_s1_tag;
        end
    end

    // Stage 3: chroma products
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_cb_r <= C_PROD_W'(r_s2_ar) * C_PROD_W'(CB_R_COEF);
            r_s3_cb_g <= C_PROD_W'(r_s2_ag) * C_PROD_W'(CB_G_COEF);
            r_s3_cb_b <= C_PROD_W'(r_s2_ab) * C_PROD_W'(CB_B_COEF);
            r_s3_cr_r <= C_PROD_W'(r_s2_ar) * C_PROD_W'(CR_R_COEF);
            r_s3_cr_g <= C_PROD_W'(r_s2_ag) * C_PROD_W'(CR_G_COEF);
            r_s3_cr_b <= C_PROD_W'(r_s2_ab) * C_PROD_W'(CR_B_COEF);
            r_s3_luma <= r_s2_luma;
            r_s3_tag  <= r_s2_tag;
        end
    end

    // Stage 4: signed chroma sums, clamp, into the output register
    assign cb_sum = C_SUM_W'(C_BIAS) + C_SUM_W'(r_s3_cb_b)
                  - C_SUM_W'(r_s3_cb_r) - C_SUM_W'(r_s3_cb_g);
    assign cr_sum = C_SUM_W'(C_BIAS) + C_SUM_W'(r_s3_cr_r)
                  - C_SUM_W'(r_s3_cr_g) - C_SUM_W'(r_s3_cr_b);
    assign cb_out = r_s3_tag.chroma ? chroma_clamp(cb_sum) : '0;
    assign cr_out = r_s3_tag.chroma ? chroma_clamp(cr_sum) : '0;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_o_luma <= r_s3_luma;
            r_o_cb   <= cb_out;
            r_o_cr   <= cr_out;
            r_o_tag  <= r_s3_tag;
        end
    end

    assign o_res.valid        = r_v4;
    assign o_res.luma         = r_o_luma;
    assign o_res.chroma_valid = r_o_tag.chroma;
    assign o_res.cb_value     = r_o_cb;
    assign o_res.cr_value     = r_o_cr;
    assign o_res.end_of_line  = r_o_tag.eol;
    assign o_res.end_of_frame = r_o_tag.eof;

    // Checks
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_o_luma >= PIX_W'(Y_MIN)) && (r_o_luma <= PIX_W'(Y_MAX)))
        else $error("luma out of studio range");
    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_o_tag.chroma) |->
            (r_o_cb >= PIX_W'(C_MIN)) && (r_o_cb <= PIX_W'(C_MAX)) &&
            (r_o_cr >= PIX_W'(C_MIN)) && (r_o_cr <= PIX_W'(C_MAX)))
        else $error("chroma out of range");
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_o_tag.chroma) |-> (r_o_cb == '0) && (r_o_cr == '0))
        else $error("chroma not cleared on a luma-only beat");
    a_eof_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_o_tag.eof) |-> r_o_tag.eol)
        else $error("end of frame without end of line");

endmodule

>>> src/rgb_to_ycbcr420_converter_unit.sv
// Top level of the RGB to YCbCr 4:2:0 converter.
// Depends on rycc_pkg, rycc_if, rycc_front, rycc_queue and rycc_back.
//
// Usage:
//   i_pix carries one RGB pixel per beat in raster order; o_res returns one
//   result per pixel, in order: luma, and on odd rows at odd columns the Cb/Cr
//   of the 2x2 block with chroma_valid set. end_of_line / end_of_frame mark the
//   last pixel of a row / frame. i_cfg writes frame_width (index 0) and
//   frame_height (index 1); it is always ready, and writes are meant for idle
//   periods between frames.
//   Path: a pixel accepted on i_pix goes through the queue hop, then the store
//   read and luma products, averages and luma clamp, chroma products, and
//   chroma clamp into the output register, before its result shows on o_res.
//   Throughput: one pixel per cycle while o_res.ready stays high; every stage,
//   including the line store write and read, handles one beat a cycle.
//   Reset: synchronous, active low; clears counters, queue and stage valids,
//   and loads width 640 and height 480. The line store needs no clearing,
//   since each entry is written on an even row before the odd row reads it.
//   Stall: when o_res.ready is low the output register holds; the pipeline
//   compacts its bubbles, then the 4-entry queue fills, and only then does
//   i_pix.ready drop.
module rgb_to_ycbcr420_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rycc_cfg_if.sink    i_cfg,
    rycc_pix_if.sink    i_pix,
    rycc_res_if.source  o_res
);
    import rycc_pkg::*;

    t_job   push_job;
    t_job   head_job;
    t_qstat qstat;
    logic   push;
    logic   pop;

    rycc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_pix   (i_pix),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    rycc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head_job)
    );

    rycc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
